/* sv/ctsp_pkg.sv */
// Shared types, codes, microcode program and reply bytes for the console tape serial port.
`default_nettype none

package ctsp_pkg;

  // Stream widths
  localparam int S_DATA_W = 16;  // operation[3:0], write_data[11:4]
  localparam int M_DATA_W = 16;  // read_data[7:0], rx_interrupt[8], tx_interrupt[9]

  localparam int RING_DEPTH_DEF = 32;

  // Register bit positions
  localparam int DONE_BIT = 7;
  localparam int IE_BIT   = 6;
  localparam int BRK_BIT  = 0;

  // Line protocol bytes
  localparam logic [7:0] BYTE_COMMAND  = 8'o002;
  localparam logic [7:0] BYTE_INIT     = 8'o004;
  localparam logic [7:0] BYTE_CONTINUE = 8'o020;
  localparam logic [3:0] PKT_LAST      = 4'd13;  // count before the closing byte
  localparam logic [3:0] IDX_CONTINUE  = 4'd14;

  // Operation codes
  localparam logic [3:0] OP_POLL     = 4'd0;
  localparam logic [3:0] OP_RD_RXST  = 4'd1;
  localparam logic [3:0] OP_WR_RXST  = 4'd2;
  localparam logic [3:0] OP_RD_RXDAT = 4'd3;
  localparam logic [3:0] OP_RD_TXST  = 4'd4;
  localparam logic [3:0] OP_WR_TXST  = 4'd5;
  localparam logic [3:0] OP_WR_TXDAT = 4'd6;
  localparam logic [3:0] OP_ACK_RX   = 4'd7;
  localparam logic [3:0] OP_ACK_TX   = 4'd8;

  typedef enum logic [3:0] {
    U_NOP, U_READ, U_PRES, U_TXPOLL, U_RXSTAT, U_WRRX, U_RDDATA,
    U_RDTX, U_WRTX, U_TXBYTE, U_ACKRX, U_ACKTX, U_PUSH
  } uop_t;

  typedef enum logic [1:0] {BR_NONE, BR_INIT, BR_PKT} br_t;

  typedef logic [5:0] uaddr_t;

  typedef struct packed {
    uop_t       act;
    logic [3:0] arg;  // reply byte index for pushes
    br_t        br;
    uaddr_t     tgt;
    logic       fin;
  } ucode_t;

  // Program entry points
  localparam uaddr_t A_POLL   = 6'd0;
  localparam uaddr_t A_RXST   = 6'd3;
  localparam uaddr_t A_WRRX   = 6'd6;
  localparam uaddr_t A_RDDAT  = 6'd7;
  localparam uaddr_t A_RDTX   = 6'd12;
  localparam uaddr_t A_WRTX   = 6'd13;
  localparam uaddr_t A_TXDAT  = 6'd14;
  localparam uaddr_t A_ACKRX  = 6'd16;
  localparam uaddr_t A_ACKTX  = 6'd17;
  localparam uaddr_t A_IDLE   = 6'd18;
  localparam uaddr_t A_INITR  = 6'd19;
  localparam uaddr_t A_REPLY  = 6'd22;
  localparam uaddr_t A_RPLEND = 6'd36;

  function automatic ucode_t uw(uop_t act, logic [3:0] arg, br_t br, uaddr_t tgt,
                                logic fin);
    ucode_t w;
    w.act = act;
    w.arg = arg;
    w.br  = br;
    w.tgt = tgt;
    w.fin = fin;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(uaddr_t a);
    ucode_t w;
    w = uw(U_NOP, 4'd0, BR_NONE, A_IDLE, 1'b1);
    if (a >= A_REPLY && a < A_RPLEND) begin
      w = uw(U_PUSH, 4'(a - A_REPLY), BR_NONE, A_IDLE, 1'b0);
    end else begin
      case (a)
        6'd0:  w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd1:  w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd2:  w = uw(U_TXPOLL, 4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd3:  w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd4:  w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd5:  w = uw(U_RXSTAT, 4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd6:  w = uw(U_WRRX,   4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd7:  w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd8:  w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd9:  w = uw(U_RDDATA, 4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd10: w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd11: w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd12: w = uw(U_RDTX,   4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd13: w = uw(U_WRTX,   4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd14: w = uw(U_TXBYTE, 4'd0, BR_INIT, A_INITR, 1'b0);
        6'd15: w = uw(U_NOP,    4'd0, BR_PKT,  A_REPLY, 1'b1);
        6'd16: w = uw(U_ACKRX,  4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd17: w = uw(U_ACKTX,  4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd19: w = uw(U_PUSH,   IDX_CONTINUE, BR_NONE, A_IDLE, 1'b0);
        6'd20: w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd21: w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b1);
        6'd36: w = uw(U_READ,   4'd0, BR_NONE, A_IDLE, 1'b0);
        6'd37: w = uw(U_PRES,   4'd0, BR_NONE, A_IDLE, 1'b1);
        default: w = uw(U_NOP,  4'd0, BR_NONE, A_IDLE, 1'b1);
      endcase
    end
    return w;
  endfunction

  function automatic uaddr_t entry_of(logic [3:0] op);
    uaddr_t a;
    unique case (op)
      OP_POLL:     a = A_POLL;
      OP_RD_RXST:  a = A_RXST;
      OP_WR_RXST:  a = A_WRRX;
      OP_RD_RXDAT: a = A_RDDAT;
      OP_RD_TXST:  a = A_RDTX;
      OP_WR_TXST:  a = A_WRTX;
      OP_WR_TXDAT: a = A_TXDAT;
      OP_ACK_RX:   a = A_ACKRX;
      OP_ACK_TX:   a = A_ACKTX;
      default:     a = A_IDLE;
    endcase
    return a;
  endfunction

  // END/no-cartridge reply, checksum low byte first; CONTINUE, the INIT reply, sits at the next index
  function automatic logic [7:0] reply_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:         b = 8'o002;
      4'd1:         b = 8'o012;
      4'd2:         b = 8'o100;
      4'd3:         b = 8'o367;
      4'd12:        b = 8'h43;
      4'd13:        b = 8'h01;
      IDX_CONTINUE: b = BYTE_CONTINUE;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* sv/console_tape_serial_port_core.sv */
// Top level: microcoded serial-line register pair with a reply ring, fronting an empty tape drive.
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  operation[3:0], write_data[11:4], zeros above
// m_*      out  m_tvalid/m_tready  read_data[7:0], rx_interrupt[8], tx_interrupt[9]
//
// Sequencing: the item is taken, then its microcode steps run in order: plain accesses, poll
// and rx status reads, rx data reads, a tx byte, INIT (which pushes CONTINUE) and the byte
// that closes a command packet (14 ring pushes). The ring has one write and one read port,
// and each step does one push or one read.
// The result is registered; the next item is taken the cycle after the last step.
// A full output register holds the last step until it drains.
// Reset is synchronous; the ring itself is not cleared and needs no clearing pass.
`default_nettype none

module console_tape_serial_port_core
  import ctsp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // operation[3:0], write_data[11:4]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // read_data[7:0], rx_int[8], tx_int[9]
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  // Reply ring
  logic [7:0]    ring [RING_DEPTH];
  logic [7:0]    mem_q;
  logic          mem_rd_en;
  logic          push_en;
  logic [AW-1:0] push_slot;
  logic [7:0]    push_byte;

  // Sequencer and item
  state_t        state, state_next;
  uaddr_t        upc, upc_next;
  logic [7:0]    wd_r, wd_r_next;
  logic          pkt_full, pkt_full_next;

  // Architectural state
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [7:0]    rx_byte, rx_byte_next;
  logic          rx_done, rx_done_next, rx_ie, rx_ie_next;
  logic          tx_done, tx_done_next, tx_ie, tx_ie_next, tx_brk, tx_brk_next;
  logic [3:0]    pkt_cnt, pkt_cnt_next;
  logic          rx_latch, rx_latch_next, tx_latch, tx_latch_next;
  logic [7:0]    rd, rd_next;

  // Output register
  logic          m_valid, m_valid_next;
  logic [7:0]    o_rd, o_rd_next;
  logic          o_rxi, o_rxi_next, o_txi, o_txi_next;

  ucode_t        w;
  logic          taken, last, stall, was, now;
  logic [AW:0]   slot_sum;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = m_valid;
  assign m_tdata  = {{(M_DATA_W-10){1'b0}}, o_txi, o_rxi, o_rd};

  // tail slot: head + count wraps once at most
  always_comb begin
    slot_sum = {1'b0, head} + (AW+1)'(count);
    if (slot_sum >= (AW+1)'(RING_DEPTH)) begin
      slot_sum = slot_sum - (AW+1)'(RING_DEPTH);
    end
    push_slot = slot_sum[AW-1:0];
  end

  always_comb begin
    state_next    = state;
    upc_next      = upc;
    wd_r_next     = wd_r;
    pkt_full_next = pkt_full;
    head_next     = head;
    count_next    = count;
    rx_byte_next  = rx_byte;
    rx_done_next  = rx_done;
    rx_ie_next    = rx_ie;
    tx_done_next  = tx_done;
    tx_ie_next    = tx_ie;
    tx_brk_next   = tx_brk;
    pkt_cnt_next  = pkt_cnt;
    rx_latch_next = rx_latch;
    tx_latch_next = tx_latch;
    rd_next       = rd;
    m_valid_next  = m_valid;
    o_rd_next     = o_rd;
    o_rxi_next    = o_rxi;
    o_txi_next    = o_txi;
    mem_rd_en     = 1'b0;
    push_en       = 1'b0;
    push_byte     = 8'h00;
    w             = ucode_rom(upc);
    taken         = 1'b0;
    last          = 1'b0;
    stall         = 1'b0;
    was           = 1'b0;
    now           = 1'b0;

    if (m_valid && m_tready) begin
      m_valid_next = 1'b0;
    end

    if (state == S_IDLE) begin
      if (s_tvalid) begin
        wd_r_next  = s_tdata[11:4];
        upc_next   = entry_of(s_tdata[3:0]);
        rd_next    = 8'h00;
        state_next = S_RUN;
      end
    end else begin
      case (w.br)
        BR_INIT: taken = (wd_r == BYTE_INIT);
        BR_PKT:  taken = pkt_full;
        default: taken = 1'b0;
      endcase
      last  = w.fin && !taken;
      stall = last && m_valid && !m_tready;

      if (!stall) begin
        case (w.act)
          U_READ: mem_rd_en = 1'b1;
          U_PRES: begin
            // move the ring head into the data register
            if (!rx_done && count != '0) begin
              rx_byte_next  = mem_q;
              head_next     = (head == AW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
              count_next    = count - 1'b1;
              rx_done_next  = 1'b1;
              rx_latch_next = rx_ie;
            end
          end
          U_TXPOLL: begin
            if (!tx_done) begin
              tx_done_next  = 1'b1;
              tx_latch_next = tx_ie;
            end
          end
          U_RXSTAT: rd_next = {rx_done, rx_ie, 6'b0};
          U_WRRX: begin
            was        = rx_done && rx_ie;
            rx_ie_next = wd_r[IE_BIT];
            now        = rx_done && wd_r[IE_BIT];
            if (now && !was) rx_latch_next = 1'b1;
            if (!now) rx_latch_next = 1'b0;
          end
          U_RDDATA: begin
            rd_next = rx_byte;
            if (rx_done) begin
              rx_done_next  = 1'b0;
              rx_latch_next = 1'b0;
            end
          end
          U_RDTX: rd_next = {tx_done, tx_ie, 5'b0, tx_brk};
          U_WRTX: begin
            was         = tx_done && tx_ie;
            tx_ie_next  = wd_r[IE_BIT];
            tx_brk_next = wd_r[BRK_BIT];
            now         = tx_done && wd_r[IE_BIT];
            if (wd_r[BRK_BIT]) begin
              // break: flush ring and packet, drop receive state
              pkt_cnt_next  = '0;
              count_next    = '0;
              head_next     = '0;
              rx_done_next  = 1'b0;
              rx_latch_next = 1'b0;
            end
            if (now && !was) tx_latch_next = 1'b1;
            if (!now) tx_latch_next = 1'b0;
          end
          U_TXBYTE: begin
            // done drops and returns within the access
            tx_done_next  = 1'b1;
            tx_latch_next = tx_ie;
            pkt_full_next = 1'b0;
            if (wd_r == BYTE_INIT) begin
              pkt_cnt_next = '0;
            end else if (wd_r == BYTE_COMMAND || pkt_cnt != '0) begin
              if (pkt_cnt == PKT_LAST) begin
                pkt_cnt_next  = '0;
                pkt_full_next = 1'b1;
              end else begin
                pkt_cnt_next = pkt_cnt + 1'b1;
              end
            end
          end
          U_ACKRX: rx_latch_next = 1'b0;
          U_ACKTX: tx_latch_next = 1'b0;
          U_PUSH: begin
            if (count < CW'(RING_DEPTH)) begin
              push_en    = 1'b1;
              push_byte  = reply_byte(w.arg);
              count_next = count + 1'b1;
            end
          end
          default: ;
        endcase

        if (taken) begin
          upc_next = w.tgt;
        end else if (last) begin
          state_next   = S_IDLE;
          m_valid_next = 1'b1;
          o_rd_next    = rd_next;
          o_rxi_next   = rx_latch_next;
          o_txi_next   = tx_latch_next;
        end else begin
          upc_next = upc + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      upc      <= A_IDLE;
      pkt_full <= 1'b0;
      head     <= '0;
      count    <= '0;
      rx_byte  <= 8'h00;
      rx_done  <= 1'b0;
      rx_ie    <= 1'b0;
      tx_done  <= 1'b1;
      tx_ie    <= 1'b0;
      tx_brk   <= 1'b0;
      pkt_cnt  <= '0;
      rx_latch <= 1'b0;
      tx_latch <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      upc      <= upc_next;
      pkt_full <= pkt_full_next;
      head     <= head_next;
      count    <= count_next;
      rx_byte  <= rx_byte_next;
      rx_done  <= rx_done_next;
      rx_ie    <= rx_ie_next;
      tx_done  <= tx_done_next;
      tx_ie    <= tx_ie_next;
      tx_brk   <= tx_brk_next;
      pkt_cnt  <= pkt_cnt_next;
      rx_latch <= rx_latch_next;
      tx_latch <= tx_latch_next;
      m_valid  <= m_valid_next;
    end
    wd_r  <= wd_r_next;
    rd    <= rd_next;
    o_rd  <= o_rd_next;
    o_rxi <= o_rxi_next;
    o_txi <= o_txi_next;
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring[push_slot] <= push_byte;
    end
    if (mem_rd_en) begin
      mem_q <= ring[head];
    end
  end

endmodule

`default_nettype wire

/* sv/ctsp_checker.sv */
// Port-level checks for the console tape serial port, bound to the top level.
`default_nettype none

module ctsp_checker
  import ctsp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [S_DATA_W-1:0] s_tdata,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // after reset: idle and nothing pending
  a_reset: assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");

  // one item at a time: taking an item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while busy");

  // a result only comes out of a running access
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a running access");

  // reserved result bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_W-1:10] == '0))
    else $error("result padding not zero");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // waiting item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("waiting item changed");

endmodule

bind console_tape_serial_port_core ctsp_checker u_ctsp_checker (.*);

`default_nettype wire
